@@ src/irl_pkg.sv @@
`default_nettype none
package irl_pkg;

	localparam int MODE_W       = 2;
	localparam int SLOT_W       = 20;
	localparam int ADDR_W       = 32;
	localparam int PREFIX_AW    = 8;
	localparam int PREFIX_DEPTH = 256;
	localparam int RECORD_DEPTH = 1048576;
	localparam int REC_AW       = $clog2(RECORD_DEPTH);

	localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	function automatic logic rec_in_range(input logic [SLOT_W-1:0] slot);
		return 32'(slot) < 32'(RECORD_DEPTH);
	endfunction

endpackage
`default_nettype wire

@@ src/irl_req_if.sv @@
`default_nettype none
interface irl_req_if;
	logic                          valid;
	logic                          ready;
	logic [irl_pkg::MODE_W-1:0]    mode;
	logic [irl_pkg::SLOT_W-1:0]    slot;
	logic [irl_pkg::SLOT_W-1:0]    range_first;
	logic [irl_pkg::SLOT_W-1:0]    range_last;
	logic [irl_pkg::ADDR_W-1:0]    end_address;
	logic [irl_pkg::ADDR_W-1:0]    ip_address;

	modport source (
		output valid, mode, slot, range_first, range_last, end_address, ip_address,
		input  ready
	);
	modport sink (
		input  valid, mode, slot, range_first, range_last, end_address, ip_address,
		output ready
	);
endinterface
`default_nettype wire

@@ src/irl_rsp_if.sv @@
`default_nettype none
interface irl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [irl_pkg::SLOT_W-1:0] record_index;

	modport source (
		output valid, record_index,
		input  ready
	);
	modport sink (
		input  valid, record_index,
		output ready
	);
endinterface
`default_nettype wire

@@ src/irl_ram.sv @@
`default_nettype none
module irl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ src/ip_range_lookup.sv @@
// Channel  Dir  Fields
// req      in   mode, slot, range_first, range_last, end_address, ip_address
// rsp      out  record_index (one item per query)
//
// A write item is done when it is accepted. A query goes through the prefix read, one search step
// per record probe and the flush that loads the result, and the next item is taken after that. A
// single slot or a reversed range needs no probe; a full slot range needs at most 21.
// The record memory is read once per probe; each probe result sets the next address.
// Reset clears the control state only; both tables must be written before they are read.
// A stalled result is held in the output register, and a new item is taken meanwhile.
`default_nettype none
module ip_range_lookup (
	input wire logic  clk,
	input wire logic  arst_n,
	irl_req_if.sink   req,
	irl_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PREFIX = 4'b0010,
		S_SEARCH = 4'b0100,
		S_FLUSH  = 4'b1000
	} state_t;

	state_t state_q;

	logic                          accept;
	logic                          pref_we;
	logic [2*irl_pkg::SLOT_W-1:0]  pref_rd;
	logic                          rec_we;
	logic [irl_pkg::ADDR_W-1:0]    rec_rd;
	logic [irl_pkg::ADDR_W-1:0]    rec_val;
	logic [irl_pkg::SLOT_W-1:0]    pf_first;
	logic [irl_pkg::SLOT_W-1:0]    pf_last;
	logic [irl_pkg::SLOT_W:0]      lo_n;
	logic [irl_pkg::SLOT_W-1:0]    hi_n;
	logic [irl_pkg::SLOT_W:0]      sum;
	logic [irl_pkg::SLOT_W-1:0]    mid_n;
	logic                          ge;
	logic                          search_end;
	logic                          out_load;

	logic [irl_pkg::ADDR_W-1:0]    key_q;
	logic [irl_pkg::SLOT_W-1:0]    lo_q;
	logic [irl_pkg::SLOT_W-1:0]    hi_q;
	logic [irl_pkg::SLOT_W-1:0]    mid_q;
	logic                          mid_oob_q;
	logic [irl_pkg::SLOT_W-1:0]    found_q;
	logic                          out_valid_q;
	logic [irl_pkg::SLOT_W-1:0]    out_index_q;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign pref_we = accept && (req.mode == irl_pkg::MODE_PREFIX)
		&& (req.slot[irl_pkg::SLOT_W-1:irl_pkg::PREFIX_AW] == '0);
	assign rec_we  = accept && (req.mode == irl_pkg::MODE_RECORD)
		&& irl_pkg::rec_in_range(req.slot);

	irl_ram #(
		.WIDTH (2*irl_pkg::SLOT_W),
		.DEPTH (irl_pkg::PREFIX_DEPTH)
	) u_prefix_ram (
		.clk     (clk),
		.wr_en   (pref_we),
		.wr_addr (req.slot[irl_pkg::PREFIX_AW-1:0]),
		.wr_data ({req.range_first, req.range_last}),
		.rd_addr (req.ip_address[irl_pkg::ADDR_W-1 -: irl_pkg::PREFIX_AW]),
		.rd_data (pref_rd)
	);

	irl_ram #(
		.WIDTH (irl_pkg::ADDR_W),
		.DEPTH (irl_pkg::RECORD_DEPTH)
	) u_record_ram (
		.clk     (clk),
		.wr_en   (rec_we),
		.wr_addr (irl_pkg::REC_AW'(req.slot)),
		.wr_data (req.end_address),
		.rd_addr (irl_pkg::REC_AW'(mid_n)),
		.rd_data (rec_rd)
	);

	assign pf_first = pref_rd[2*irl_pkg::SLOT_W-1:irl_pkg::SLOT_W];
	assign pf_last  = pref_rd[irl_pkg::SLOT_W-1:0];
	assign rec_val  = mid_oob_q ? '0 : rec_rd;
	assign ge       = (rec_val >= key_q);

	always_comb begin
		if (state_q == S_PREFIX) begin
			lo_n = {1'b0, pf_first};
			hi_n = pf_last;
		end else if (ge) begin
			lo_n = {1'b0, lo_q};
			hi_n = mid_q - irl_pkg::SLOT_W'(1);
		end else begin
			lo_n = {1'b0, mid_q} + (irl_pkg::SLOT_W+1)'(1);
			hi_n = hi_q;
		end
		sum        = {1'b0, lo_n[irl_pkg::SLOT_W-1:0]} + {1'b0, hi_n};
		mid_n      = sum[irl_pkg::SLOT_W:1];
		search_end = (lo_n > {1'b0, hi_n}) || (ge && (mid_q == '0));
	end

	assign out_load = (state_q == S_FLUSH) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (req.mode == irl_pkg::MODE_QUERY)) begin
						state_q <= S_PREFIX;
					end
				end
				S_PREFIX: begin
					if (pf_first >= pf_last) begin
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (search_end) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req.ip_address;
		end
		if (state_q == S_PREFIX) begin
			found_q <= (pf_first == pf_last) ? pf_first : '0;
		end else if ((state_q == S_SEARCH) && ge) begin
			found_q <= mid_q;
		end
		if ((state_q == S_PREFIX) || ((state_q == S_SEARCH) && !search_end)) begin
			lo_q      <= lo_n[irl_pkg::SLOT_W-1:0];
			hi_q      <= hi_n;
			mid_q     <= mid_n;
			mid_oob_q <= !irl_pkg::rec_in_range(mid_n);
		end
		if (out_load) begin
			out_index_q <= found_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.record_index = out_index_q;

`ifndef SYNTH
	a_query_reads_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.mode == irl_pkg::MODE_QUERY) |=> state_q == S_PREFIX)
		else $error("query item did not start a prefix read");

	a_search_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> $past(state_q) == S_PREFIX || $past(state_q) == S_SEARCH)
		else $error("search entered from wrong state");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> lo_q <= mid_q && mid_q <= hi_q)
		else $error("probe slot outside search bounds");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> rsp.valid && rsp.record_index == $past(found_q))
		else $error("result not loaded into output register");

	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pref_we || rec_we) |-> state_q == S_IDLE)
		else $error("table write outside idle state");
`endif

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

	localparam logic [irl_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [irl_pkg::SLOT_W-1:0] SLOT_MAX = '1;
	localparam int RANDOM_ITEMS = 700;
	localparam int MAX_WAIT = 17;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [irl_pkg::MODE_W-1:0] mode;
		logic [irl_pkg::SLOT_W-1:0] slot;
		logic [irl_pkg::SLOT_W-1:0] range_first;
		logic [irl_pkg::SLOT_W-1:0] range_last;
		logic [irl_pkg::ADDR_W-1:0] end_address;
		logic [irl_pkg::ADDR_W-1:0] ip_address;
	} lookup_req_t;

	logic clk;
	logic arst_n;
	irl_req_if req ();
	irl_rsp_if rsp ();

	ip_range_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic [irl_pkg::SLOT_W-1:0] pfx_first [irl_pkg::PREFIX_DEPTH];
	logic [irl_pkg::SLOT_W-1:0] pfx_last [irl_pkg::PREFIX_DEPTH];
	bit pfx_valid [irl_pkg::PREFIX_DEPTH];
	logic [7:0] pfx_used [$];
	logic [irl_pkg::ADDR_W-1:0] end_addr_mem [int];
	logic [irl_pkg::SLOT_W-1:0] expected_index_q [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int sent_count = 0;
	int req_calm = 0;
	int rsp_calm = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Each side either waits a random number of cycles per item or runs through
	// a stretch of items with no waiting at all.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Returns the expected slot for a query. Sets missing to the first record
	// slot that the search would read before it was ever written, or -1.
	function automatic logic [irl_pkg::SLOT_W-1:0] predict_record_index(
		input logic [irl_pkg::ADDR_W-1:0] addr, output int missing);
		logic [7:0] p;
		longint lo;
		longint hi;
		longint mid;
		logic [irl_pkg::SLOT_W-1:0] found;
		logic [irl_pkg::ADDR_W-1:0] probe;
		p = addr[31:24];
		lo = pfx_first[p];
		hi = pfx_last[p];
		found = '0;
		missing = -1;
		if (lo == hi) begin
			if (!end_addr_mem.exists(int'(lo)))
				missing = int'(lo);
			return irl_pkg::SLOT_W'(lo);
		end
		while (lo <= hi) begin
			mid = (lo + hi) >> 1;
			if (mid >= irl_pkg::RECORD_DEPTH) begin
				probe = '0;
			end else if (!end_addr_mem.exists(int'(mid))) begin
				missing = int'(mid);
				return '0;
			end else begin
				probe = end_addr_mem[int'(mid)];
			end
			if (probe >= addr) begin
				found = irl_pkg::SLOT_W'(mid);
				if (mid == 0)
					break;
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return found;
	endfunction

	function automatic void apply_item(input lookup_req_t it);
		int missing;
		case (it.mode)
			irl_pkg::MODE_PREFIX: begin
				if (it.slot < irl_pkg::PREFIX_DEPTH) begin
					if (!pfx_valid[it.slot[7:0]])
						pfx_used.push_back(it.slot[7:0]);
					pfx_valid[it.slot[7:0]] = 1'b1;
					pfx_first[it.slot[7:0]] = it.range_first;
					pfx_last[it.slot[7:0]] = it.range_last;
				end
			end
			irl_pkg::MODE_RECORD: begin
				if (32'(it.slot) < irl_pkg::RECORD_DEPTH)
					end_addr_mem[int'(it.slot)] = it.end_address;
			end
			irl_pkg::MODE_QUERY: begin
				expected_index_q.push_back(predict_record_index(it.ip_address, missing));
			end
			default: begin
			end
		endcase
	endfunction

	function automatic lookup_req_t rand_item(input logic [irl_pkg::MODE_W-1:0] mode);
		lookup_req_t it;
		it.mode = mode;
		it.slot = irl_pkg::SLOT_W'($urandom);
		it.range_first = irl_pkg::SLOT_W'($urandom);
		it.range_last = irl_pkg::SLOT_W'($urandom);
		it.end_address = $urandom;
		it.ip_address = $urandom;
		return it;
	endfunction

	task automatic send_item(input lookup_req_t it);
		int gap;
		gap = draw_wait(req_calm);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= it.mode;
		req.slot <= it.slot;
		req.range_first <= it.range_first;
		req.range_last <= it.range_last;
		req.end_address <= it.end_address;
		req.ip_address <= it.ip_address;
		do @(posedge clk); while (!req.ready);
		apply_item(it);
		sent_count++;
	endtask

	task automatic program_prefix(input logic [7:0] p,
		input logic [irl_pkg::SLOT_W-1:0] first, input logic [irl_pkg::SLOT_W-1:0] last);
		lookup_req_t it;
		it = rand_item(irl_pkg::MODE_PREFIX);
		it.slot = irl_pkg::SLOT_W'(p);
		it.range_first = first;
		it.range_last = last;
		send_item(it);
	endtask

	task automatic write_record(input logic [irl_pkg::SLOT_W-1:0] s,
		input logic [irl_pkg::ADDR_W-1:0] value);
		lookup_req_t it;
		it = rand_item(irl_pkg::MODE_RECORD);
		it.slot = s;
		it.end_address = value;
		send_item(it);
	endtask

	task automatic send_query(input logic [irl_pkg::ADDR_W-1:0] addr);
		lookup_req_t it;
		it = rand_item(irl_pkg::MODE_QUERY);
		it.ip_address = addr;
		send_item(it);
	endtask

	// End address for a slot, spread evenly over the prefix's address block so
	// that each slot range is sorted.
	function automatic logic [irl_pkg::ADDR_W-1:0] spread_end(input logic [7:0] p,
		input longint s);
		longint lo;
		longint hi;
		longint off;
		lo = pfx_first[p];
		hi = pfx_last[p];
		if (hi <= lo || s < lo || s > hi)
			return $urandom;
		off = ((s - lo + 1) <<< 24) / (hi - lo + 1);
		return {p, 24'h0} + irl_pkg::ADDR_W'(off) - 1;
	endfunction

	function automatic void pick_range(output logic [irl_pkg::SLOT_W-1:0] first,
		output logic [irl_pkg::SLOT_W-1:0] last);
		case ($urandom_range(0, 9))
			0: begin
				first = irl_pkg::SLOT_W'($urandom_range(0, 255));
				last = SLOT_MAX - irl_pkg::SLOT_W'($urandom_range(0, 255));
			end
			1: begin
				first = irl_pkg::SLOT_W'($urandom_range(1, SLOT_MAX));
				last = irl_pkg::SLOT_W'($urandom_range(0, first - 1));
			end
			2: begin
				first = irl_pkg::SLOT_W'($urandom);
				last = first;
			end
			3: begin
				last = SLOT_MAX;
				first = SLOT_MAX - irl_pkg::SLOT_W'($urandom_range(1, 63));
			end
			4: begin
				first = '0;
				last = irl_pkg::SLOT_W'($urandom_range(1, 63));
			end
			default: begin
				first = irl_pkg::SLOT_W'($urandom);
				if (first > SLOT_MAX - 64)
					last = SLOT_MAX;
				else
					last = first + irl_pkg::SLOT_W'($urandom_range(1, 63));
			end
		endcase
	endfunction

	// Programs the prefix if it is unset, writes whatever the search for this address
	// would read unwritten, then sends the query.
	task automatic lookup(input logic [irl_pkg::ADDR_W-1:0] addr);
		int missing;
		logic [irl_pkg::SLOT_W-1:0] first;
		logic [irl_pkg::SLOT_W-1:0] last;
		if (!pfx_valid[addr[31:24]]) begin
			pick_range(first, last);
			program_prefix(addr[31:24], first, last);
		end
		void'(predict_record_index(addr, missing));
		while (missing >= 0) begin
			if ($urandom_range(0, 7) == 0)
				write_record(irl_pkg::SLOT_W'(missing), $urandom);
			else
				write_record(irl_pkg::SLOT_W'(missing), spread_end(addr[31:24], missing));
			void'(predict_record_index(addr, missing));
		end
		send_query(addr);
	endtask

	task automatic test_ignored_items();
		lookup_req_t it;
		send_item(rand_item(MODE_UNUSED));
		it = rand_item(irl_pkg::MODE_PREFIX);
		it.slot = irl_pkg::SLOT_W'(irl_pkg::PREFIX_DEPTH);
		send_item(it);
		it.slot = SLOT_MAX;
		it.range_first = SLOT_MAX;
		it.range_last = '0;
		send_item(it);
	endtask

	task automatic test_single_slot();
		write_record(SLOT_MAX, '1);
		program_prefix(8'hFF, SLOT_MAX, SLOT_MAX);
		send_query('1);
		send_query(32'hFF00_0000);
	endtask

	task automatic test_reversed_range();
		program_prefix(8'h80, SLOT_MAX, '0);
		send_query(32'h8000_0000);
		send_query(32'h80FF_FFFF);
	endtask

	task automatic test_search_to_slot_zero();
		program_prefix(8'h00, 20'd0, 20'd3);
		write_record(20'd0, 32'h0000_0010);
		write_record(20'd1, 32'h0000_0020);
		write_record(20'd2, 32'h0000_0030);
		write_record(20'd3, 32'h00FF_FFFF);
		send_query(32'h0000_0000);
		send_query(32'h0000_0015);
		send_query(32'h00FF_FFFF);
	endtask

	task automatic test_no_match();
		program_prefix(8'h7F, 20'd100, 20'd101);
		write_record(20'd100, 32'h7F00_0000);
		write_record(20'd101, 32'h7F80_0000);
		send_query(32'h7FFF_FFFF);
	endtask

	task automatic test_random_traffic();
		int pick;
		logic [7:0] p;
		logic [irl_pkg::SLOT_W-1:0] first;
		logic [irl_pkg::SLOT_W-1:0] last;
		longint s;
		lookup_req_t it;
		logic [irl_pkg::ADDR_W-1:0] addr;
		while (sent_count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				if ($urandom_range(0, 1) == 0) begin
					it = rand_item(MODE_UNUSED);
				end else begin
					it = rand_item(irl_pkg::MODE_PREFIX);
					it.slot = irl_pkg::SLOT_W'($urandom_range(irl_pkg::PREFIX_DEPTH,
						SLOT_MAX));
				end
				send_item(it);
			end else if (pick < 17) begin
				p = 8'($urandom);
				pick_range(first, last);
				program_prefix(p, first, last);
			end else if (pick < 27) begin
				if (pfx_used.size() > 0) begin
					p = pfx_used[$urandom_range(0, pfx_used.size() - 1)];
					if (pfx_first[p] <= pfx_last[p]) begin
						s = longint'(pfx_first[p])
							+ $urandom_range(0, pfx_last[p] - pfx_first[p]);
						write_record(irl_pkg::SLOT_W'(s),
							spread_end(p, s) + irl_pkg::ADDR_W'($urandom_range(0, 2)) - 1);
					end
				end
			end else if (pick < 35) begin
				write_record(irl_pkg::SLOT_W'($urandom), $urandom);
			end else begin
				if (pfx_used.size() > 0 && $urandom_range(0, 4) != 0)
					p = pfx_used[$urandom_range(0, pfx_used.size() - 1)];
				else
					p = 8'($urandom);
				addr = {p, 24'($urandom)};
				case ($urandom_range(0, 9))
					5, 6, 7: begin
						if (pfx_valid[p] && pfx_first[p] <= pfx_last[p]) begin
							s = longint'(pfx_first[p])
								+ $urandom_range(0, pfx_last[p] - pfx_first[p]);
							if (end_addr_mem.exists(int'(s)))
								addr = end_addr_mem[int'(s)]
									+ irl_pkg::ADDR_W'($urandom_range(0, 2)) - 1;
						end
					end
					8: addr = {p, 24'h00_0000};
					9: addr = {p, 24'hFF_FFFF};
					default: begin
					end
				endcase
				lookup(addr);
			end
		end
	endtask

	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_wait(rsp_calm);
			@(negedge clk);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_index_q.size() == 0) begin
				report_mismatch($sformatf("record_index %0h with no query outstanding",
					rsp.record_index));
			end else begin
				if (rsp.record_index !== expected_index_q[0])
					report_mismatch($sformatf("record_index %0h, expected %0h",
						rsp.record_index, expected_index_q[0]));
				void'(expected_index_q.pop_front());
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = '0;
		req.slot = '0;
		req.range_first = '0;
		req.range_last = '0;
		req.end_address = '0;
		req.ip_address = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_ignored_items();
		test_single_slot();
		test_reversed_range();
		test_search_to_slot_zero();
		test_no_match();
		test_random_traffic();

		@(negedge clk);
		req.valid <= 1'b0;
		while (expected_index_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
